/* src/bta_pkg.sv */
// Package for the balanced ternary ALU: word sizes, operation codes, trit
// encoding helpers and the carry-map type used by the parallel carry prefix.
// No dependencies.
`default_nettype none

package bta_pkg;

	localparam int MAX_TRITS = 32;
	localparam int WORD_W = 2 * MAX_TRITS;
	localparam int TRIT_COUNT_DEF = 32;

	// Trit codes in the packed word.
	localparam logic [1:0] TRIT_ZERO = 2'b00;
	localparam logic [1:0] TRIT_POS = 2'b01;
	localparam logic [1:0] TRIT_NEG = 2'b10;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_AND = 3'd2,
		OP_OR  = 3'd3,
		OP_XOR = 3'd4,
		OP_NOT = 3'd5
	} op_t;

	// A carry map gives the carry out of a group of trits for each of the
	// three possible carries into it, each held as a trit code.
	typedef struct packed {
		logic [1:0] m_neg;
		logic [1:0] m_zero;
		logic [1:0] m_pos;
	} cmap_t;

	// Decode a trit code to a small signed value; code 11 reads as zero.
	function automatic logic signed [2:0] trit_dec(input logic [1:0] code);
		logic signed [2:0] v;
		unique case (code)
			TRIT_POS: v = 3'sd1;
			TRIT_NEG: v = -3'sd1;
			default:  v = 3'sd0;
		endcase
		return v;
	endfunction

	// Encode a value in -1..1 as a trit code.
	function automatic logic [1:0] trit_enc(input logic signed [2:0] v);
		logic [1:0] c;
		priority if (v > 3'sd0) c = TRIT_POS;
		else if (v < 3'sd0) c = TRIT_NEG;
		else c = TRIT_ZERO;
		return c;
	endfunction

	// Sum digit of a balanced sum in -3..3, reduced modulo 3 into -1..1.
	function automatic logic [1:0] trit_wrap(input logic signed [2:0] s);
		logic [1:0] c;
		unique case (s)
			3'sd1, -3'sd2: c = TRIT_POS;
			-3'sd1, 3'sd2: c = TRIT_NEG;
			default:       c = TRIT_ZERO;
		endcase
		return c;
	endfunction

	// Carry out of a balanced sum in -3..3.
	function automatic logic [1:0] carry_of(input logic signed [2:0] s);
		logic [1:0] c;
		priority if (s > 3'sd1) c = TRIT_POS;
		else if (s < -3'sd1) c = TRIT_NEG;
		else c = TRIT_ZERO;
		return c;
	endfunction

	function automatic logic [1:0] cmap_apply(input cmap_t m, input logic [1:0] cin);
		logic [1:0] c;
		unique case (cin)
			TRIT_POS: c = m.m_pos;
			TRIT_NEG: c = m.m_neg;
			default:  c = m.m_zero;
		endcase
		return c;
	endfunction

	// Map of f followed by g: f covers the lower trits, g the upper ones.
	function automatic cmap_t cmap_compose(input cmap_t g, input cmap_t f);
		cmap_t h;
		h.m_neg = cmap_apply(g, f.m_neg);
		h.m_zero = cmap_apply(g, f.m_zero);
		h.m_pos = cmap_apply(g, f.m_pos);
		return h;
	endfunction

endpackage

`default_nettype wire

/* src/balanced_ternary_alu.sv */
// Top level of the balanced ternary ALU: input register, trit-wise logic with
// a parallel carry prefix for add and subtract, and result register.
// Depends on bta_pkg.
`default_nettype none

// Balanced ternary ALU over TRIT_COUNT trits packed two bits per trit (00 zero,
// 01 plus one, 10 minus one, 11 read as zero). Operations are add, subtract,
// trit-wise product (and), maximum (or), negated product (xor) and negate
// (not); unused operation codes give zero. The block takes one word per clock
// cycle while the output side is not stalled. A word is captured in the input
// register when accepted, its result is computed in one pass and captured in
// the output register, which drives result and out_valid until it is taken.
// The longest path is the add/subtract carry, formed by a Kogge-Stone prefix of
// clog2(TRIT_COUNT) levels of carry-map composition rather than a ripple.
// The carry out of the top trit is dropped, so sums wrap modulo 3^TRIT_COUNT.
// Result trits at and above TRIT_COUNT are zero, and every result trit uses the
// canonical codes only. A stall on the output holds the output register, and
// the input register too once it is full; in_ready follows out_ready
// combinationally when both registers are full.
module balanced_ternary_alu #(
	parameter int TRIT_COUNT = bta_pkg::TRIT_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [2:0]                  op,
	input  wire logic [bta_pkg::WORD_W-1:0]  operand_a,
	input  wire logic [bta_pkg::WORD_W-1:0]  operand_b,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [bta_pkg::WORD_W-1:0]  result
);
	import bta_pkg::*;

	localparam int LVLS = (TRIT_COUNT > 1) ? $clog2(TRIT_COUNT) : 1;

	// Pipeline registers.
	logic              valid_s1;
	logic [2:0]        op_s1;
	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] res_s2;

	logic adv_s2;
	logic adv_s1;
	logic [WORD_W-1:0] res_d;

	// The output register takes a new word when it is empty or being drained;
	// the input register moves whenever its word can move on.
	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1 <= op;
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// Per-trit operand values and the carry map of each trit position.
	logic signed [2:0] ta [TRIT_COUNT];
	logic signed [2:0] tb [TRIT_COUNT];
	cmap_t             pre [LVLS+1][TRIT_COUNT];
	logic [1:0]        cin [TRIT_COUNT];
	logic [1:0]        digit [TRIT_COUNT];

	genvar gi, gk;
	generate
		for (gi = 0; gi < TRIT_COUNT; gi++) begin : g_trit
			logic signed [2:0] pair;
			logic signed [2:0] sum;
			logic signed [2:0] prod;

			assign ta[gi] = trit_dec(a_s1[2*gi +: 2]);
			// Subtract adds the negated second operand.
			assign tb[gi] = (op_s1 == OP_SUB) ? -trit_dec(b_s1[2*gi +: 2])
				: trit_dec(b_s1[2*gi +: 2]);
			assign pair = ta[gi] + tb[gi];
			assign sum = pair + trit_dec(cin[gi]);
			assign prod = ta[gi] * tb[gi];

			assign pre[0][gi].m_neg = carry_of(pair - 3'sd1);
			assign pre[0][gi].m_zero = carry_of(pair);
			assign pre[0][gi].m_pos = carry_of(pair + 3'sd1);

			if (gi == 0) begin : g_first
				assign cin[gi] = TRIT_ZERO;
			end else begin : g_rest
				assign cin[gi] = pre[LVLS][gi-1].m_zero;
			end

			always_comb begin
				unique case (op_s1)
					OP_ADD, OP_SUB: digit[gi] = trit_wrap(sum);
					OP_AND:         digit[gi] = trit_enc(prod);
					OP_OR:          digit[gi] = trit_enc((ta[gi] > tb[gi]) ? ta[gi] : tb[gi]);
					OP_XOR:         digit[gi] = trit_enc(-prod);
					OP_NOT:         digit[gi] = trit_enc(-ta[gi]);
					default:        digit[gi] = TRIT_ZERO;
				endcase
			end
		end

		// Kogge-Stone prefix: after level k each position covers the 2^(k+1)
		// trits ending at it, so the last level gives the carry out of all
		// trits from zero up to that position.
		for (gk = 0; gk < LVLS; gk++) begin : g_lvl
			for (gi = 0; gi < TRIT_COUNT; gi++) begin : g_pos
				if (gi >= (1 << gk)) begin : g_cmb
					assign pre[gk+1][gi] = cmap_compose(pre[gk][gi], pre[gk][gi-(1 << gk)]);
				end else begin : g_pass
					assign pre[gk+1][gi] = pre[gk][gi];
				end
			end
		end

		for (gi = 0; gi < MAX_TRITS; gi++) begin : g_out
			if (gi < TRIT_COUNT) begin : g_used
				assign res_d[2*gi +: 2] = digit[gi];
			end else begin : g_unused
				assign res_d[2*gi +: 2] = TRIT_ZERO;
			end
		end
	endgenerate

	assign out_valid = valid_s2;
	assign result = res_s2;

	// Assertions.
	localparam logic [WORD_W-1:0] LO_BITS = {MAX_TRITS{2'b01}};

	a_no_code11: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result & (result >> 1) & LO_BITS) == '0))
		else $error("result holds a non-canonical trit code");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result >> (2 * TRIT_COUNT)) == '0))
		else $error("result trits above TRIT_COUNT are not zero");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (valid_s1 && op_s1 == $past(op)))
		else $error("accepted word not captured in input register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(op_s1) && $stable(a_s1)
			&& $stable(b_s1)))
		else $error("input register changed while output stalled");

endmodule

`default_nettype wire
